// ===== sv/tcw_pkg.sv =====
// Shared definitions for the text console writer: field widths, character codes,
// default geometry and the controller state type. No dependencies.
package tcw_pkg;

	localparam int COLUMNS_DEF  = 80;
	localparam int ROWS_DEF     = 25;
	localparam int TAB_STEP_DEF = 4;

	localparam int CMD_W   = 1;
	localparam int CHAR_W  = 8;
	localparam int IDX_W   = 11;
	localparam int CELL_W  = 16;
	localparam int COLOR_W = 8;
	localparam int COL_W   = 7;
	localparam int ROW_W   = 5;

	localparam logic [CMD_W-1:0] CMD_PUT  = 1'b0;
	localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

	localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CODE_TAB     = 8'd9;
	localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;

	localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;
	localparam logic [CELL_W-1:0]  RESET_CELL  = {RESET_COLOR, BLANK_CHAR};

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_COPY,
		ST_FILL,
		ST_DONE
	} tcw_state_t;

endpackage

// ===== sv/tcw_in_if.sv =====
// Command channel of the text console writer: valid/ready plus one command beat.
// Depends on tcw_pkg for the field widths.
interface tcw_in_if
	import tcw_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [CHAR_W-1:0] char_code;
	logic [IDX_W-1:0]  cell_index;

	modport source (output valid, output command, output char_code, output cell_index,
		input ready);
	modport sink (input valid, input command, input char_code, input cell_index,
		output ready);
endinterface

// ===== sv/tcw_out_if.sv =====
// Result channel of the text console writer: valid/ready plus one result beat.
// Depends on tcw_pkg for the field widths.
interface tcw_out_if
	import tcw_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CELL_W-1:0] cell_entry;
	logic [COL_W-1:0]  cursor_column;
	logic [ROW_W-1:0]  cursor_row;
	logic              scrolled;

	modport source (output valid, output cell_entry, output cursor_column,
		output cursor_row, output scrolled, input ready);
	modport sink (input valid, input cell_entry, input cursor_column,
		input cursor_row, input scrolled, output ready);
endinterface

// ===== sv/tcw_screen_ram.sv =====
// Screen store: simple dual-port RAM, one write and one registered read per cycle.
// Depends on tcw_pkg for the cell width.
module tcw_screen_ram
	import tcw_pkg::*;
#(
	parameter int DEPTH = COLUMNS_DEF * ROWS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [CELL_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/text_console_writer_top.sv =====
// Text console writer, top level: cursor, screen store controller and channel registers.
// Depends on tcw_pkg, tcw_in_if, tcw_out_if and tcw_screen_ram.
//
// A character console of ROWS x COLUMNS cells, each cell holding the attribute byte
// in bits 15:8 and the character in bits 7:0. After reset the block runs a clearing
// pass that writes every cell to a light grey blank, one cell per cycle, before the
// first command beat is accepted; cfg writes are taken during that pass. A put beat
// (command 0) prints the character at the cursor, or moves the cursor for newline and
// tab, and returns the new cursor with cell_entry 0. A read beat (command 1) returns
// the addressed cell, or 0 when cell_index lies beyond the screen. A put goes from the
// accepting cycle to ST_DONE, and a read passes through ST_READ first, since the
// screen RAM read is registered; ST_DONE loads the result into the output register
// once that is free. When the cursor leaves the last row the screen scrolls: the
// controller streams every cell of rows 1 and below up one row through the RAM's read
// and write ports, one cell per cycle, then fills the bottom row with blanks in the
// current text colour (color_q). One command is in work at a time; a new beat can be
// accepted while the previous result still waits in the output register.
module text_console_writer_top
	import tcw_pkg::*;
#(
	parameter int COLUMNS  = COLUMNS_DEF,
	parameter int ROWS     = ROWS_DEF,
	parameter int TAB_STEP = TAB_STEP_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	tcw_in_if.sink             in_ch,
	tcw_out_if.source          out_ch,
	input  logic               cfg_we,
	input  logic [COLOR_W-1:0] cfg_data
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $clog2(ROWS);
	localparam int SW    = COL_W + 1;

	localparam logic [AW-1:0] LAST_ADDR  = AW'(CELLS - 1);
	localparam logic [AW-1:0] ROW1_ADDR  = AW'(COLUMNS);
	localparam logic [AW-1:0] LROW_ADDR  = AW'((ROWS - 1) * COLUMNS);
	localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);

	tcw_state_t state_q, state_d;

	// Sweep pointer for the clearing pass, the scroll copy and the bottom-row fill.
	logic [AW-1:0]      ptr_q;
	logic [COL_W-1:0]   col_q;
	logic [RW-1:0]      row_q;
	logic [COLOR_W-1:0] color_q;

	// Write stage for a scroll: a copy write lands in the cycle after its RAM read.
	logic               wr_s1;
	logic               fill_s1;
	logic [AW-1:0]      waddr_s1;

	logic               rd_ok_q;
	logic [CELL_W-1:0]  res_entry_q;
	logic [COL_W-1:0]   res_col_q;
	logic [ROW_W-1:0]   res_row_q;
	logic               res_scroll_q;

	logic               out_valid_q;
	logic [CELL_W-1:0]  out_entry_q;
	logic [COL_W-1:0]   out_col_q;
	logic [ROW_W-1:0]   out_row_q;
	logic               out_scroll_q;

	logic               accept;
	logic               out_free;
	logic               is_put;
	logic               is_printed;
	logic               wrap;
	logic               need_scroll;
	logic [SW-1:0]      col_sum;
	logic [COL_W-1:0]   col_n;
	logic [RW-1:0]      row_n;
	logic [AW-1:0]      cursor_addr;
	logic               idx_ok;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [CELL_W-1:0]  mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;
	logic [CELL_W-1:0]  mem_rdata;

	tcw_screen_ram #(
		.DEPTH(CELLS),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;

	// Cursor movement for a put beat.
	assign is_put      = (in_ch.command == CMD_PUT);
	assign is_printed  = (in_ch.char_code != CODE_NEWLINE) && (in_ch.char_code != CODE_TAB);
	assign col_sum     = (in_ch.char_code == CODE_TAB) ? ({1'b0, col_q} + SW'(TAB_STEP))
		: ({1'b0, col_q} + SW'(1));
	assign wrap        = (in_ch.char_code == CODE_NEWLINE) || (col_sum >= SW'(COLUMNS));
	assign need_scroll = wrap && (row_q == LAST_ROW);
	assign col_n       = wrap ? '0 : col_sum[COL_W-1:0];
	assign row_n       = !wrap ? row_q : (need_scroll ? row_q : row_q + RW'(1));

	assign cursor_addr = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
	assign idx_ok      = (int'(in_ch.cell_index) < CELLS);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (ptr_q == LAST_ADDR) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (!is_put) state_d = ST_READ;
					else if (need_scroll) state_d = ST_COPY;
					else state_d = ST_DONE;
				end
			end
			ST_READ: state_d = ST_DONE;
			ST_COPY: begin
				if (ptr_q == LAST_ADDR) state_d = ST_FILL;
			end
			ST_FILL: begin
				if (ptr_q == LAST_ADDR) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// RAM port control.
	always_comb begin
		mem_we    = wr_s1;
		mem_waddr = waddr_s1;
		mem_wdata = fill_s1 ? {color_q, BLANK_CHAR} : mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = ptr_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
				mem_wdata = RESET_CELL;
			end
			ST_IDLE: begin
				mem_we    = accept && is_put && is_printed;
				mem_waddr = cursor_addr;
				mem_wdata = {color_q, in_ch.char_code};
				mem_re    = accept && !is_put && idx_ok;
				mem_raddr = AW'(in_ch.cell_index);
			end
			ST_COPY: mem_re = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			ptr_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			color_q     <= RESET_COLOR;
			wr_s1       <= 1'b0;
			fill_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) color_q <= cfg_data;
			wr_s1   <= 1'b0;
			fill_s1 <= 1'b0;
			case (state_q)
				ST_CLEAR: ptr_q <= ptr_q + AW'(1);
				ST_IDLE: begin
					if (accept && is_put) begin
						col_q <= col_n;
						row_q <= row_n;
						ptr_q <= ROW1_ADDR;
					end
				end
				ST_COPY: begin
					wr_s1 <= 1'b1;
					ptr_q <= (ptr_q == LAST_ADDR) ? LROW_ADDR : ptr_q + AW'(1);
				end
				ST_FILL: begin
					wr_s1   <= 1'b1;
					fill_s1 <= 1'b1;
					ptr_q   <= ptr_q + AW'(1);
				end
				default: ;
			endcase
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					rd_ok_q      <= idx_ok;
					res_entry_q  <= '0;
					res_col_q    <= is_put ? col_n : col_q;
					res_row_q    <= ROW_W'(is_put ? row_n : row_q);
					res_scroll_q <= is_put && need_scroll;
				end
			end
			ST_READ: res_entry_q <= rd_ok_q ? mem_rdata : '0;
			ST_COPY: waddr_s1 <= ptr_q - ROW1_ADDR;
			ST_FILL: waddr_s1 <= ptr_q;
			ST_DONE: begin
				if (out_free) begin
					out_entry_q  <= res_entry_q;
					out_col_q    <= res_col_q;
					out_row_q    <= res_row_q;
					out_scroll_q <= res_scroll_q;
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.cell_entry    = out_entry_q;
	assign out_ch.cursor_column = out_col_q;
	assign out_ch.cursor_row    = out_row_q;
	assign out_ch.scrolled      = out_scroll_q;

endmodule
